>>> hw/rtl/stable_price_sorter_assert.svh
// Assertion macros for the stable price sorter.
// Used by the top level; expects aclk and aresetn in scope.
`ifndef STABLE_PRICE_SORTER_ASSERT_SVH
`define STABLE_PRICE_SORTER_ASSERT_SVH

// same-cycle check: ante implies cons
`define SPS_CHECK(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle check: ante implies cons
`define SPS_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/sps_pkg.sv
// Shared types and constants for the stable price sorter.
// No dependencies.
package sps_pkg;

    localparam int ID_BITS    = 8;
    localparam int KIND_BITS  = 2;
    localparam int PRICE_BITS = 16;

    // pass-through part of a record
    typedef struct packed {
        logic [ID_BITS-1:0]   id;
        logic [KIND_BITS-1:0] kind;
    } meta_t;

endpackage

>>> hw/rtl/sps_store.sv
// Record memory and taken-mark memory, one write and one registered read port.
// Depends on sps_pkg.
module sps_store #(
    parameter int DEPTH    = 64,
    parameter int KEY_BITS = 16,
    parameter int IDX_W    = 6
) (
    input  logic                aclk,
    input  logic                rec_we,
    input  logic                tk_we,
    input  logic [IDX_W-1:0]    waddr,
    input  sps_pkg::meta_t      wmeta,
    input  logic [KEY_BITS-1:0] wprice,
    input  logic                tk_wdata,
    input  logic [IDX_W-1:0]    raddr,
    output sps_pkg::meta_t      rmeta,
    output logic [KEY_BITS-1:0] rprice,
    output logic                rtaken
);
    import sps_pkg::*;

    meta_t               meta_mem  [DEPTH];
    logic [KEY_BITS-1:0] price_mem [DEPTH];
    logic                taken_mem [DEPTH];

    meta_t               rmeta_reg;
    logic [KEY_BITS-1:0] rprice_reg;
    logic                rtaken_reg;

    always_ff @(posedge aclk) begin
        if (rec_we) begin
            meta_mem[waddr]  <= wmeta;
            price_mem[waddr] <= wprice;
        end
        rmeta_reg  <= meta_mem[raddr];
        rprice_reg <= price_mem[raddr];
    end

    always_ff @(posedge aclk) begin
        if (tk_we) begin
            taken_mem[waddr] <= tk_wdata;
        end
        rtaken_reg <= taken_mem[raddr];
    end

    assign rmeta  = rmeta_reg;
    assign rprice = rprice_reg;
    assign rtaken = rtaken_reg;

endmodule

>>> hw/rtl/sps_select.sv
// Shared compare unit: keeps the cheapest untaken record seen in a scan.
// Depends on sps_pkg.
module sps_select #(
    parameter int KEY_BITS = 16,
    parameter int IDX_W    = 6
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                clr,
    input  logic                smp_valid,
    input  logic                smp_taken,
    input  logic [KEY_BITS-1:0] smp_price,
    input  sps_pkg::meta_t      smp_meta,
    input  logic [IDX_W-1:0]    smp_idx,
    output logic [KEY_BITS-1:0] best_price,
    output sps_pkg::meta_t      best_meta,
    output logic [IDX_W-1:0]    best_idx
);
    import sps_pkg::*;

    logic                found_reg;
    logic [KEY_BITS-1:0] price_reg;
    meta_t               meta_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic                take;

    // strict less-than: earlier index keeps a tie
    assign take = smp_valid && !smp_taken && (!found_reg || (smp_price < price_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else if (clr) begin
            found_reg <= 1'b0;
        end else if (take) begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (take && !clr) begin
            price_reg <= smp_price;
            meta_reg  <= smp_meta;
            idx_reg   <= smp_idx;
        end
    end

    assign best_price = price_reg;
    assign best_meta  = meta_reg;
    assign best_idx   = idx_reg;

endmodule

>>> hw/rtl/stable_price_sorter.sv
// Stable selection sorter. Load: one item per cycle, no result unless last_entry.
// Sort of n stored records: each result takes one full scan of the n entries plus
// any output stall; the single record-memory read port bounds the scan, one entry
// compared per cycle. s_ready is low while sorting.
// Reset (aresetn low, synchronous) empties the batch and clears the output valid.
`include "stable_price_sorter_assert.svh"

module stable_price_sorter #(
    parameter int MAX_ENTRIES = 64,
    parameter int KEY_BITS    = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input channel: one record per item
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [sps_pkg::ID_BITS-1:0]      s_dish_id,
    input  logic [sps_pkg::KIND_BITS-1:0]    s_dish_kind,
    input  logic [sps_pkg::PRICE_BITS-1:0]   s_price,
    input  logic                             s_last_entry,
    // result channel: sorted records
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [sps_pkg::ID_BITS-1:0]      m_out_id,
    output logic [sps_pkg::KIND_BITS-1:0]    m_out_kind,
    output logic [sps_pkg::PRICE_BITS-1:0]   m_out_price,
    output logic                             m_end_of_list,
    output logic                             m_overflow
);
    import sps_pkg::*;

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    // sequencer states
    localparam logic [2:0] S_LOAD = 3'd0;  // taking records
    localparam logic [2:0] S_SCAN = 3'd1;  // issuing reads 0..n-1
    localparam logic [2:0] S_LAST = 3'd2;  // last read compared
    localparam logic [2:0] S_PICK = 3'd3;  // mark winner, load output
    localparam logic [2:0] S_EMIT = 3'd4;  // wait for result taken

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             dropped_reg, dropped_next;
    logic [IDX_W-1:0] j_reg, j_next;       // scan read address
    logic [IDX_W-1:0] k_reg, k_next;       // result number in batch
    logic             rd_vld_reg;          // marks the read data valid
    logic [IDX_W-1:0] rd_idx_reg;          // address behind the read data

    logic                m_valid_reg, m_valid_next;
    meta_t               out_meta_reg;
    logic [KEY_BITS-1:0] out_price_reg;
    logic                out_eol_reg;
    logic                out_ovf_reg;

    // memory hookup
    logic                rec_we, tk_we, tk_wdata;
    logic [IDX_W-1:0]    waddr;
    meta_t               wmeta;
    logic [KEY_BITS-1:0] wprice;
    meta_t               rmeta;
    logic [KEY_BITS-1:0] rprice;
    logic                rtaken;

    // selector hookup
    logic                sel_clr;
    logic [KEY_BITS-1:0] best_price;
    meta_t               best_meta;
    logic [IDX_W-1:0]    best_idx;

    logic in_fire, out_fire, has_room, last_read, last_result;

    assign s_ready  = (state_reg == S_LOAD);
    assign in_fire  = s_valid && s_ready;
    assign out_fire = m_valid_reg && m_ready;
    assign has_room = (count_reg < CNT_W'(MAX_ENTRIES));

    // count is never zero once sorting starts
    assign last_read   = (CNT_W'(j_reg) == (count_reg - CNT_W'(1)));
    assign last_result = (CNT_W'(k_reg) == (count_reg - CNT_W'(1)));

    assign wmeta.id   = s_dish_id;
    assign wmeta.kind = s_dish_kind;
    assign wprice     = KEY_BITS'(s_price);

    // load writes a record and clears its taken mark; pick sets the winner's mark
    always_comb begin
        rec_we   = 1'b0;
        tk_we    = 1'b0;
        tk_wdata = 1'b0;
        waddr    = count_reg[IDX_W-1:0];
        if (state_reg == S_LOAD) begin
            rec_we = in_fire && has_room;
            tk_we  = in_fire && has_room;
        end else if (state_reg == S_PICK) begin
            tk_we    = 1'b1;
            tk_wdata = 1'b1;
            waddr    = best_idx;
        end
    end

    // fresh scan starts whenever address 0 is issued
    assign sel_clr = (state_reg == S_SCAN) && (j_reg == '0);

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        dropped_next = dropped_reg;
        j_next       = j_reg;
        k_next       = k_reg;
        m_valid_next = m_valid_reg;
        case (state_reg)
            S_LOAD: begin
                if (in_fire) begin
                    if (has_room) begin
                        count_next = count_reg + CNT_W'(1);
                    end else begin
                        dropped_next = 1'b1;
                    end
                    if (s_last_entry) begin
                        state_next = S_SCAN;
                        j_next     = '0;
                        k_next     = '0;
                    end
                end
            end
            S_SCAN: begin
                if (last_read) begin
                    state_next = S_LAST;
                end else begin
                    j_next = j_reg + IDX_W'(1);
                end
            end
            S_LAST: begin
                state_next = S_PICK;
            end
            S_PICK: begin
                m_valid_next = 1'b1;
                state_next   = S_EMIT;
            end
            S_EMIT: begin
                if (out_fire) begin
                    m_valid_next = 1'b0;
                    if (out_eol_reg) begin
                        // batch done: empty it
                        state_next   = S_LOAD;
                        count_next   = '0;
                        dropped_next = 1'b0;
                    end else begin
                        state_next = S_SCAN;
                        j_next     = '0;
                        k_next     = k_reg + IDX_W'(1);
                    end
                end
            end
            default: begin
                state_next   = S_LOAD;
                m_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_LOAD;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            j_reg       <= '0;
            k_reg       <= '0;
            rd_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
            j_reg       <= j_next;
            k_reg       <= k_next;
            rd_vld_reg  <= (state_reg == S_SCAN);
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg <= j_reg;
        if (state_reg == S_PICK) begin
            out_meta_reg  <= best_meta;
            out_price_reg <= best_price;
            out_eol_reg   <= last_result;
            out_ovf_reg   <= dropped_reg;
        end
    end

    sps_store #(
        .DEPTH    (MAX_ENTRIES),
        .KEY_BITS (KEY_BITS),
        .IDX_W    (IDX_W)
    ) u_store (
        .aclk     (aclk),
        .rec_we   (rec_we),
        .tk_we    (tk_we),
        .waddr    (waddr),
        .wmeta    (wmeta),
        .wprice   (wprice),
        .tk_wdata (tk_wdata),
        .raddr    (j_reg),
        .rmeta    (rmeta),
        .rprice   (rprice),
        .rtaken   (rtaken)
    );

    sps_select #(
        .KEY_BITS (KEY_BITS),
        .IDX_W    (IDX_W)
    ) u_select (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .clr        (sel_clr),
        .smp_valid  (rd_vld_reg),
        .smp_taken  (rtaken),
        .smp_price  (rprice),
        .smp_meta   (rmeta),
        .smp_idx    (rd_idx_reg),
        .best_price (best_price),
        .best_meta  (best_meta),
        .best_idx   (best_idx)
    );

    assign m_valid       = m_valid_reg;
    assign m_out_id      = out_meta_reg.id;
    assign m_out_kind    = out_meta_reg.kind;
    assign m_out_price   = PRICE_BITS'(out_price_reg);
    assign m_end_of_list = out_eol_reg;
    assign m_overflow    = out_ovf_reg;

    // loading and emitting never overlap
    `SPS_CHECK(a_no_overlap, s_ready, !m_valid_reg, "input ready while a result is pending")
    // fill count stays within capacity
    `SPS_CHECK(a_count_cap, 1'b1, count_reg <= CNT_W'(MAX_ENTRIES), "entry count past capacity")
    // a sort only runs on a non-empty batch
    `SPS_CHECK(a_scan_nonempty, state_reg != S_LOAD, count_reg != '0, "sort started on empty batch")
    // taking the final result reopens the input
    `SPS_NEXT(a_eol_reopen, out_fire && out_eol_reg, s_ready && count_reg == '0,
              "batch not emptied after final result")

endmodule

>>> tb/sv/price_sort_scoreboard.sv
`timescale 1ns / 1ps
// Scoreboard for stable_price_sorter: predicts the sorted output of each batch.
// Depends on sps_pkg; observes both handshakes and reports a mismatch count.
module price_sort_scoreboard #(
    parameter int CAPACITY = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic [sps_pkg::ID_BITS-1:0]     s_dish_id,
    input  logic [sps_pkg::KIND_BITS-1:0]   s_dish_kind,
    input  logic [sps_pkg::PRICE_BITS-1:0]  s_price,
    input  logic                            s_last_entry,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic [sps_pkg::ID_BITS-1:0]     m_out_id,
    input  logic [sps_pkg::KIND_BITS-1:0]   m_out_kind,
    input  logic [sps_pkg::PRICE_BITS-1:0]  m_out_price,
    input  logic                            m_end_of_list,
    input  logic                            m_overflow,
    output int                              mismatches,
    output int                              awaited
);

    typedef struct packed {
        sps_pkg::meta_t                  meta;
        logic [sps_pkg::PRICE_BITS-1:0]  price;
        logic                            eol;
        logic                            ovf;
    } sorted_rec_t;

    logic [sps_pkg::PRICE_BITS-1:0] held_price [CAPACITY];
    sps_pkg::meta_t                 held_meta  [CAPACITY];
    int                             held_count = 0;
    bit                             batch_dropped = 1'b0;
    sorted_rec_t                    sorted_q[$];

    initial begin
        mismatches = 0;
        awaited    = 0;
    end

    // selection scan; strict less-than keeps the earlier record on a tie
    function automatic void queue_sorted_batch();
        bit          taken [CAPACITY];
        int          best;
        sorted_rec_t rec;
        foreach (taken[j]) taken[j] = 1'b0;
        for (int k = 0; k < held_count; k++) begin
            best = -1;
            for (int j = 0; j < held_count; j++) begin
                if (!taken[j] && (best < 0 || held_price[j] < held_price[best]))
                    best = j;
            end
            taken[best] = 1'b1;
            rec.meta  = held_meta[best];
            rec.price = held_price[best];
            rec.eol   = (k == held_count - 1);
            rec.ovf   = batch_dropped;
            sorted_q  = {sorted_q, rec};
        end
        held_count    = 0;
        batch_dropped = 1'b0;
    endfunction

    function automatic void compare_field(input string fname, input int unsigned want_v,
                                          input int unsigned got_v);
        if (want_v != got_v) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want_v, got_v);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin
        sorted_rec_t want;
        if (!aresetn) begin
            held_count    = 0;
            batch_dropped = 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (sorted_q.size() == 0) begin
                    $display("%0t: unexpected record id %0d kind %0d price %0d", $time,
                             m_out_id, m_out_kind, m_out_price);
                    mismatches++;
                end else begin
                    want = sorted_q.pop_front();
                    compare_field("out_id",      want.meta.id,   m_out_id);
                    compare_field("out_kind",    want.meta.kind, m_out_kind);
                    compare_field("out_price",   want.price,     m_out_price);
                    compare_field("end_of_list", want.eol,       m_end_of_list);
                    compare_field("overflow",    want.ovf,       m_overflow);
                end
            end
            if (s_valid && s_ready) begin
                if (held_count < CAPACITY) begin
                    held_meta[held_count].id   = s_dish_id;
                    held_meta[held_count].kind = s_dish_kind;
                    held_price[held_count]     = s_price;
                    held_count++;
                end else begin
                    batch_dropped = 1'b1;
                end
                if (s_last_entry) queue_sorted_batch();
            end
        end
        awaited <= sorted_q.size();
    end

endmodule

>>> tb/sv/stable_price_sorter_tb.sv
`timescale 1ns / 1ps
// Top of the stable_price_sorter testbench: clock, reset, batch stimulus, verdict.
// Depends on sps_pkg, stable_price_sorter and price_sort_scoreboard.
module stable_price_sorter_tb;

    localparam int CAPACITY     = 64;
    localparam int IDLE_LIMIT   = 4000;  // cycles with no item moving on either side
    localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
    localparam int DRAIN_CYCLES = 100;   // quiet time after the last record
    localparam int PHASE_ITEMS  = 4;     // minimum small-batch items per idling phase

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    logic [sps_pkg::ID_BITS-1:0]    s_dish_id = '0;
    logic [sps_pkg::KIND_BITS-1:0]  s_dish_kind = '0;
    logic [sps_pkg::PRICE_BITS-1:0] s_price = '0;
    logic                           s_last_entry = 1'b0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    logic [sps_pkg::ID_BITS-1:0]    m_out_id;
    logic [sps_pkg::KIND_BITS-1:0]  m_out_kind;
    logic [sps_pkg::PRICE_BITS-1:0] m_out_price;
    logic                           m_end_of_list;
    logic                           m_overflow;

    int sort_fails;
    int sort_awaited;

    // idling knobs, percent of cycles; written by the stimulus only
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    // hold-off handshake: stimulus bumps the request, receiver tracks what it served
    int hold_reqs   = 0;
    int hold_served = 0;
    int hold_left   = 0;
    int idle_cycles = 0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    stable_price_sorter #(
        .MAX_ENTRIES(CAPACITY),
        .KEY_BITS   (sps_pkg::PRICE_BITS)
    ) u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_dish_id    (s_dish_id),
        .s_dish_kind  (s_dish_kind),
        .s_price      (s_price),
        .s_last_entry (s_last_entry),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_id     (m_out_id),
        .m_out_kind   (m_out_kind),
        .m_out_price  (m_out_price),
        .m_end_of_list(m_end_of_list),
        .m_overflow   (m_overflow)
    );

    price_sort_scoreboard #(
        .CAPACITY(CAPACITY)
    ) u_sort_board (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_dish_id    (s_dish_id),
        .s_dish_kind  (s_dish_kind),
        .s_price      (s_price),
        .s_last_entry (s_last_entry),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_id     (m_out_id),
        .m_out_kind   (m_out_kind),
        .m_out_price  (m_out_price),
        .m_end_of_list(m_end_of_list),
        .m_overflow   (m_overflow),
        .mismatches   (sort_fails),
        .awaited      (sort_awaited)
    );

    // Receiver: one ready decision per falling edge. A pending hold-off request
    // takes priority and keeps ready low for HOLD_CYCLES, so a sorted batch backs
    // up inside the block while the sender keeps offering the next batch.
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_reqs) begin
            m_ready     <= 1'b0;
            hold_left   <= HOLD_CYCLES - 1;
            hold_served <= hold_reqs;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Watchdog: any accepted item on either side restarts the count.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offer one record. Entered and left at a falling edge; valid is only
    // lowered while idling, so a back-to-back item keeps valid high.
    task automatic send_record(input logic [sps_pkg::ID_BITS-1:0] id,
                               input logic [sps_pkg::KIND_BITS-1:0] kind,
                               input logic [sps_pkg::PRICE_BITS-1:0] price,
                               input logic last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_dish_id    <= id;
        s_dish_kind  <= kind;
        s_price      <= price;
        s_last_entry <= last;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // One batch of random records; prices lean toward ties and the extremes.
    task automatic random_batch(input int count);
        logic [sps_pkg::PRICE_BITS-1:0] price;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 3))
                0:       price = 16'($urandom_range(0, 3));
                1:       price = $urandom_range(0, 1) ? '1 : '0;
                default: price = 16'($urandom_range(0, 16'hFFFF));
            endcase
            send_record(8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)), price,
                        i == count - 1);
        end
    endtask

    initial begin
        int phase_items;
        int batch_len;

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // --- directed: single records at both extremes
        send_record(8'hFF, 2'd3, 16'hFFFF, 1'b1);
        send_record(8'h00, 2'd0, 16'h0000, 1'b1);
        // mixed batch with two pairs of equal prices; load order must survive
        send_record(8'd10, 2'd0, 16'd500,   1'b0);
        send_record(8'd11, 2'd1, 16'd7,     1'b0);
        send_record(8'd12, 2'd2, 16'd500,   1'b0);
        send_record(8'd13, 2'd3, 16'd0,     1'b0);
        send_record(8'd14, 2'd1, 16'hFFFF,  1'b0);
        send_record(8'd15, 2'd2, 16'd7,     1'b1);
        // every price equal: output order is load order
        send_record(8'hA5, 2'd1, 16'd1234,  1'b0);
        send_record(8'h5A, 2'd2, 16'd1234,  1'b0);
        send_record(8'hFF, 2'd3, 16'd1234,  1'b0);
        send_record(8'h00, 2'd0, 16'd1234,  1'b1);
        // already ascending, then strictly descending
        send_record(8'd20, 2'd0, 16'd0,     1'b0);
        send_record(8'd21, 2'd1, 16'd1,     1'b0);
        send_record(8'd22, 2'd2, 16'hFFFF,  1'b1);
        send_record(8'd30, 2'd3, 16'hFFFF,  1'b0);
        send_record(8'd31, 2'd2, 16'd40000, 1'b0);
        send_record(8'd32, 2'd1, 16'd20000, 1'b0);
        send_record(8'd33, 2'd0, 16'd1,     1'b0);
        send_record(8'd34, 2'd3, 16'd0,     1'b1);

        // --- random batches over four idling phases
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
                default: begin send_idle_pct = 19; recv_stall_pct = 19; end
            endcase
            // long output back-pressure while the next batch is offered
            if (phase == 2) hold_reqs++;
            // over capacity: full store, then extra records and the closing one dropped
            if (phase == 3) random_batch(CAPACITY + 2);
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                batch_len = $urandom_range(1, 4);
                random_batch(batch_len);
                phase_items += batch_len;
            end
        end

        s_valid <= 1'b0;
        while (sort_awaited != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sort_fails == 0 && sort_awaited == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
